// File: hw/rtl/ppe_pkg.sv
// Shared constants, types and helper functions of the piecewise polynomial evaluator.
package ppe_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned DEF_MAX_DEGREE   = 7;
  localparam int unsigned DEF_MAX_SEGMENTS = 8;
  localparam int unsigned DEF_COEF_WIDTH   = 32;

  // Fixed field widths and table size.
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned TAU_W       = 16;
  localparam int unsigned IN_COEF_W   = 32;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned DEG_W       = 4;
  localparam int unsigned FACT_W      = 12;
  localparam int unsigned SEGU_W      = 3;
  localparam int unsigned NUM_ORDERS  = 4;
  localparam int unsigned ONE_Q15     = 32768;
  localparam int unsigned FRAC_SHIFT  = 15;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned CFG_DEG_W  = 3;
  localparam int unsigned CFG_SEG_W  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_DEGREE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 1'd1;

  // Operation codes of an input transaction.
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Saturation limits of the accumulators.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Control word that travels with each transaction along the cell chain.
  typedef struct packed {
    logic              wr;
    logic              sat;
    logic [DEG_W-1:0]  deg;
    logic [IDX_W-1:0]  base;
    logic [IDX_W-1:0]  widx;
    logic [TAU_W-1:0]  tau;
    logic [SEGU_W-1:0] seg;
  } ppe_ctl_t;

  // Falling factorial n(n-1)...(n-m+1) for derivative order m (at most three).
  function automatic logic [FACT_W-1:0] falling_fact(input logic [DEG_W-1:0] n,
                                                     input int unsigned m);
    int unsigned prod;
    prod = 1;
    for (int unsigned j = 0; j < NUM_ORDERS - 1; j++) begin
      if (j < m) begin
        prod = (int'(n) > int'(j)) ? prod * (int'(n) - j) : 0;
      end
    end
    return FACT_W'(prod);
  endfunction

endpackage

// File: hw/rtl/ppe_if.sv
// Valid/ready channel interfaces for evaluator requests and results.
interface ppe_in_if;
  import ppe_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [IDX_W-1:0]            coef_index;
  logic signed [IN_COEF_W-1:0] coef_value;
  logic [TAU_W-1:0]            tau;

  modport source (output valid, operation, coef_index, coef_value, tau, input ready);
  modport sink (input valid, operation, coef_index, coef_value, tau, output ready);
endinterface

interface ppe_out_if;
  import ppe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] value;
  logic signed [ACC_W-1:0] first_derivative;
  logic signed [ACC_W-1:0] second_derivative;
  logic signed [ACC_W-1:0] third_derivative;
  logic [SEGU_W-1:0]       segment_used;
  logic                    saturated;

  modport source (output valid, value, first_derivative, second_derivative,
                  third_derivative, segment_used, saturated, input ready);
  modport sink (input valid, value, first_derivative, second_derivative,
                third_derivative, segment_used, saturated, output ready);
endinterface

// File: hw/rtl/ppe_cell.sv
// One Horner cell: a table replica, coefficient read, multiply and accumulate for four orders.
module ppe_cell
  import ppe_pkg::*;
#(
  parameter int unsigned TERM       = 0,
  parameter int unsigned COEF_WIDTH = DEF_COEF_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  ppe_ctl_t                           ctl_i,
  input  logic [COEF_WIDTH-1:0]              wdata_i,
  input  logic [NUM_ORDERS-1:0][ACC_W-1:0]   acc_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output ppe_ctl_t                           ctl_o,
  output logic [COEF_WIDTH-1:0]              wdata_o,
  output logic [NUM_ORDERS-1:0][ACC_W-1:0]   acc_o
);

  localparam int unsigned PW  = ACC_W + TAU_W + 1;
  localparam int unsigned CFW = COEF_WIDTH + FACT_W + 1;
  localparam int unsigned SW  = ((CFW > ACC_W) ? CFW : ACC_W) + 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(ONE_Q15 / 2);

  // Stage registers.
  logic                             v1_q, v2_q, v3_q;
  logic                             r1, r2, r3;
  ppe_ctl_t                         ctl1_q, ctl2_q, ctl3_q;
  logic [COEF_WIDTH-1:0]            wd1_q, wd2_q, wd3_q;
  logic [NUM_ORDERS-1:0][ACC_W-1:0] acc1_q, acc2_q, acc3_q;
  logic [COEF_WIDTH-1:0]            coef_q;
  logic [FACT_W-1:0]                fct1_q [NUM_ORDERS];
  logic [NUM_ORDERS-1:0]            act1_q, act2_q;
  logic signed [PW-1:0]             prod_q [NUM_ORDERS];
  logic signed [CFW-1:0]            cf_q [NUM_ORDERS];
  logic [COEF_WIDTH-1:0]            mem_q [TABLE_DEPTH];

  logic [IDX_W-1:0]                 rd_addr;
  logic [DEG_W-1:0]                 n_term;
  logic [NUM_ORDERS-1:0]            act_d;
  logic [FACT_W-1:0]                fct_d [NUM_ORDERS];
  logic signed [PW-1:0]             prod_d [NUM_ORDERS];
  logic signed [CFW-1:0]            cf_d [NUM_ORDERS];
  logic [NUM_ORDERS-1:0][ACC_W-1:0] acc3_d;
  logic                             sat3_d;
  ppe_ctl_t                         ctl3_d;

  // Each stage moves on when it is empty or its successor takes its transaction.
  assign r3      = !v3_q || ready_i;
  assign r2      = !v2_q || r3;
  assign r1      = !v1_q || r2;
  assign ready_o = r1;

  // Term address and per-order activity for the incoming transaction.
  assign rd_addr = ctl_i.base + IDX_W'(TERM);
  assign n_term  = ctl_i.deg - DEG_W'(TERM);
  always_comb begin
    for (int unsigned m = 0; m < NUM_ORDERS; m++) begin
      act_d[m] = ({1'b0, ctl_i.deg} >= (DEG_W+1)'(TERM + m));
      fct_d[m] = falling_fact(n_term, m);
    end
  end

  // Local copy of the coefficient table; writes are applied in transaction order.
  always_ff @(posedge clk_i) begin
    if (r1 && valid_i && ctl_i.wr) begin
      mem_q[ctl_i.widx] <= wdata_i;
    end
    if (r1) begin
      coef_q <= mem_q[rd_addr];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  // Multiplications: accumulator by tau and coefficient by the derivative factor.
  always_comb begin
    for (int unsigned m = 0; m < NUM_ORDERS; m++) begin
      prod_d[m] = $signed(acc1_q[m]) * $signed({1'b0, ctl1_q.tau});
      cf_d[m]   = $signed(coef_q) * $signed({1'b0, fct1_q[m]});
    end
  end

  // Rounding, saturation and accumulation.
  always_comb begin
    logic signed [PW-1:0]    rs;
    logic signed [ACC_W-1:0] rc;
    logic signed [SW-1:0]    sm;
    sat3_d = ctl2_q.sat;
    for (int unsigned m = 0; m < NUM_ORDERS; m++) begin
      rs = (prod_q[m] + RND_HALF) >>> FRAC_SHIFT;
      if (rs > PW'(ACC_MAX)) begin
        rc = ACC_MAX;
        sat3_d = sat3_d | act2_q[m];
      end else if (rs < PW'(ACC_MIN)) begin
        rc = ACC_MIN;
        sat3_d = sat3_d | act2_q[m];
      end else begin
        rc = rs[ACC_W-1:0];
      end
      sm = SW'(rc) + SW'(cf_q[m]);
      if (sm > SW'(ACC_MAX)) begin
        acc3_d[m] = ACC_MAX;
        sat3_d = sat3_d | act2_q[m];
      end else if (sm < SW'(ACC_MIN)) begin
        acc3_d[m] = ACC_MIN;
        sat3_d = sat3_d | act2_q[m];
      end else begin
        acc3_d[m] = sm[ACC_W-1:0];
      end
      if (!act2_q[m]) begin
        acc3_d[m] = acc2_q[m];
      end
    end
  end

  // Control word of the last stage with the updated saturation flag.
  always_comb begin
    ctl3_d     = ctl2_q;
    ctl3_d.sat = sat3_d;
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (r1) begin
      ctl1_q <= ctl_i;
      wd1_q  <= wdata_i;
      acc1_q <= acc_i;
      act1_q <= act_d;
      fct1_q <= fct_d;
    end
    if (r2) begin
      ctl2_q <= ctl1_q;
      wd2_q  <= wd1_q;
      acc2_q <= acc1_q;
      act2_q <= act1_q;
      prod_q <= prod_d;
      cf_q   <= cf_d;
    end
    if (r3) begin
      ctl3_q <= ctl3_d;
      wd3_q  <= wd2_q;
      acc3_q <= acc3_d;
    end
  end

  assign valid_o = v3_q;
  assign ctl_o   = ctl3_q;
  assign wdata_o = wd3_q;
  assign acc_o   = acc3_q;

endmodule

// File: hw/rtl/piecewise_poly_eval_derivs.sv
// Top level of the piecewise polynomial evaluator with first to third derivatives.
// The block takes one transaction per cycle while the output is not stalled, writes and
// evaluations alike, and returns one result per evaluation. The path is one front stage that
// picks the segment, then one three-stage Horner cell per polynomial term, then the output
// register. The cell chain is what sets the latency.
// Each cell keeps its own copy of the 64-entry coefficient table; writes travel down
// the chain, so they take effect in transaction order. The table is not cleared at
// reset, and an entry must be written before an evaluation reads it.
module piecewise_poly_eval_derivs
  import ppe_pkg::*;
#(
  parameter int unsigned MAX_DEGREE   = DEF_MAX_DEGREE,
  parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int unsigned COEF_WIDTH   = DEF_COEF_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ppe_in_if.sink                req_i,
  ppe_out_if.source             rsp_o
);

  localparam int unsigned NCELL  = MAX_DEGREE + 1;
  localparam int unsigned SC_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned NUM_W  = TAU_W + SC_W;
  localparam int unsigned BASE_W = DEG_W + 1 + SC_W;

  // Configuration registers.
  logic [CFG_DEG_W-1:0] deg_cfg_q;
  logic [CFG_SEG_W-1:0] seg_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_cfg_q <= CFG_DEG_W'(3);
      seg_cfg_q <= CFG_SEG_W'(8);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLY_DEGREE:   deg_cfg_q <= cfg_wdata_i[CFG_DEG_W-1:0];
        CFG_SEGMENT_COUNT: seg_cfg_q <= cfg_wdata_i[CFG_SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective degree and segment count.
  logic [DEG_W-1:0] deg_eff;
  logic [SC_W-1:0]  segs_eff;

  always_comb begin
    if (int'(deg_cfg_q) > int'(MAX_DEGREE)) begin
      deg_eff = DEG_W'(MAX_DEGREE);
    end else begin
      deg_eff = DEG_W'(deg_cfg_q);
    end
    if (seg_cfg_q == '0) begin
      segs_eff = SC_W'(1);
    end else if (int'(seg_cfg_q) > int'(MAX_SEGMENTS)) begin
      segs_eff = SC_W'(MAX_SEGMENTS);
    end else begin
      segs_eff = SC_W'(seg_cfg_q);
    end
  end

  // Front stage: clamp tau, select the segment and its table base.
  logic [TAU_W-1:0]  tau_cl;
  logic              tau_sat;
  logic [NUM_W-1:0]  num, seg_raw;
  logic [SC_W-1:0]   seg_sel, seg_m1;
  logic [BASE_W-1:0] base_full;
  ppe_ctl_t          ctl_d;

  always_comb begin
    tau_sat = (req_i.tau > TAU_W'(ONE_Q15));
    tau_cl  = tau_sat ? TAU_W'(ONE_Q15) : req_i.tau;
    num     = NUM_W'(tau_cl) * NUM_W'(segs_eff);
    seg_raw = (num + NUM_W'(ONE_Q15 - 1)) >> FRAC_SHIFT;
    if (seg_raw == '0) begin
      seg_sel = SC_W'(1);
    end else if (seg_raw > NUM_W'(segs_eff)) begin
      seg_sel = segs_eff;
    end else begin
      seg_sel = seg_raw[SC_W-1:0];
    end
    seg_m1    = seg_sel - SC_W'(1);
    base_full = (BASE_W'(deg_eff) + BASE_W'(1)) * BASE_W'(seg_m1);
    ctl_d.wr   = (req_i.operation == OP_WRITE);
    ctl_d.sat  = tau_sat;
    ctl_d.deg  = deg_eff;
    ctl_d.base = base_full[IDX_W-1:0];
    ctl_d.widx = req_i.coef_index;
    ctl_d.tau  = tau_cl;
    ctl_d.seg  = seg_m1[SEGU_W-1:0];
  end

  // Chain links.
  logic                             vld_c [NCELL+1];
  logic                             rdy_c [NCELL+1];
  ppe_ctl_t                         ctl_c [NCELL+1];
  logic [COEF_WIDTH-1:0]            wd_c  [NCELL+1];
  logic [NUM_ORDERS-1:0][ACC_W-1:0] acc_c [NCELL+1];

  logic                  v0_q;
  logic                  rdy0;
  ppe_ctl_t              ctl0_q;
  logic [COEF_WIDTH-1:0] wd0_q;

  assign rdy0        = !v0_q || rdy_c[0];
  assign req_i.ready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0) begin
      ctl0_q <= ctl_d;
      wd0_q  <= COEF_WIDTH'(req_i.coef_value);
    end
  end

  assign vld_c[0] = v0_q;
  assign ctl_c[0] = ctl0_q;
  assign wd_c[0]  = wd0_q;
  assign acc_c[0] = '0;

  // One Horner cell per polynomial term.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    ppe_cell #(
      .TERM       (k),
      .COEF_WIDTH (COEF_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_c[k]),
      .ready_o (rdy_c[k]),
      .ctl_i   (ctl_c[k]),
      .wdata_i (wd_c[k]),
      .acc_i   (acc_c[k]),
      .valid_o (vld_c[k+1]),
      .ready_i (rdy_c[k+1]),
      .ctl_o   (ctl_c[k+1]),
      .wdata_o (wd_c[k+1]),
      .acc_o   (acc_c[k+1])
    );
  end

  // Output register; write transactions leave the chain here without a result.
  logic                             out_valid_q;
  logic                             out_rdy;
  logic [NUM_ORDERS-1:0][ACC_W-1:0] out_acc_q;
  logic [SEGU_W-1:0]                out_seg_q;
  logic                             out_sat_q;

  assign out_rdy      = !out_valid_q || rsp_o.ready;
  assign rdy_c[NCELL] = out_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= vld_c[NCELL] && !ctl_c[NCELL].wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy) begin
      out_acc_q <= acc_c[NCELL];
      out_seg_q <= ctl_c[NCELL].seg;
      out_sat_q <= ctl_c[NCELL].sat;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.value             = out_acc_q[0];
  assign rsp_o.first_derivative  = out_acc_q[1];
  assign rsp_o.second_derivative = out_acc_q[2];
  assign rsp_o.third_derivative  = out_acc_q[3];
  assign rsp_o.segment_used      = out_seg_q;
  assign rsp_o.saturated         = out_sat_q;

  // The front stage only refuses a transaction while it holds one.
  a_front_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> v0_q)
    else $error("front stage stalls while empty");

  // Tau above one is flagged as saturated in the front stage.
  a_tau_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && req_i.operation == OP_EVAL &&
     req_i.tau > TAU_W'(ONE_Q15)) |=> ctl0_q.sat)
    else $error("clamped tau not flagged");

  // A write transaction leaving the chain never produces a result.
  a_write_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_c[NCELL] && ctl_c[NCELL].wr && out_rdy) |=> !out_valid_q)
    else $error("write transaction produced a result");

  // With a degree below three the third derivative is zero.
  a_low_degree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && deg_eff < DEG_W'(3)) |-> (out_acc_q[3] == '0))
    else $error("third derivative non-zero for low degree");

endmodule
